// ===== design/assert_macros.svh =====
// Assertion macros for the magnetometer heading top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off while arst_n is low
`define MHU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while arst_n is low
`define MHU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mhu_pkg.sv =====
// Package: widths, constants, types and the arctangent table of the heading unit.
`timescale 1ns / 1ps
`default_nettype none
package mhu_pkg;

	localparam int AXIS_W    = 16;
	localparam int HEAD_W    = 15;
	localparam int BYTE_W    = 8;
	localparam int TABLE_LEN = 24;
	localparam int IDX_W     = 5;
	localparam int IN_SHIFT  = 14;
	// vector path: 16-bit sample, 14 bits of fraction, headroom for CORDIC gain
	localparam int VEC_W     = 34;
	// angle accumulator in 2^-16 degree units, covers about +-512 degrees
	localparam int ANG_W     = 26;
	localparam int LUT_W     = 22;
	localparam int RND_SHIFT = 10;
	localparam int ROUND_W   = ANG_W - RND_SHIFT;

	localparam int STATUS_READY_BIT = 0;

	localparam logic signed [ANG_W-1:0] ANG_ZERO = '0;
	localparam logic signed [ANG_W-1:0] ANG_90   = 26'sd5898240;
	localparam logic signed [ANG_W-1:0] ANG_180  = 26'sd11796480;
	localparam logic signed [ANG_W-1:0] RND_HALF = 26'sd512;

	localparam logic signed [ROUND_W-1:0] STEPS_FULL = 16'sd23040;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ITER,
		ST_ROUND,
		ST_EMIT
	} mhu_state_t;

	// sequencer commands to the shared CORDIC step unit
	typedef struct packed {
		logic             load;
		logic             step;
		logic [IDX_W-1:0] idx;
	} mhu_cordic_ctrl_t;

	// atan(2^-i) in degrees times 65536, rounded to nearest
	function automatic logic [LUT_W-1:0] atan_lut(input logic [IDX_W-1:0] i);
		logic [LUT_W-1:0] t;
		case (i)
			5'd0:    t = 22'd2949120;
			5'd1:    t = 22'd1740967;
			5'd2:    t = 22'd919879;
			5'd3:    t = 22'd466945;
			5'd4:    t = 22'd234379;
			5'd5:    t = 22'd117304;
			5'd6:    t = 22'd58666;
			5'd7:    t = 22'd29335;
			5'd8:    t = 22'd14668;
			5'd9:    t = 22'd7334;
			5'd10:   t = 22'd3667;
			5'd11:   t = 22'd1833;
			5'd12:   t = 22'd917;
			5'd13:   t = 22'd458;
			5'd14:   t = 22'd229;
			5'd15:   t = 22'd115;
			5'd16:   t = 22'd57;
			5'd17:   t = 22'd29;
			5'd18:   t = 22'd14;
			5'd19:   t = 22'd7;
			5'd20:   t = 22'd4;
			5'd21:   t = 22'd2;
			5'd22:   t = 22'd1;
			default: t = 22'd0;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

// ===== design/mhu_if.sv =====
// Interfaces: poll input channel and heading result channel.
`timescale 1ns / 1ps
`default_nettype none
interface mhu_in_if import mhu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] status_byte;
	logic [BYTE_W-1:0] x_low;
	logic [BYTE_W-1:0] x_high;
	logic [BYTE_W-1:0] y_low;
	logic [BYTE_W-1:0] y_high;
	logic [BYTE_W-1:0] z_low;
	logic [BYTE_W-1:0] z_high;

	modport source (output valid, status_byte, x_low, x_high, y_low, y_high, z_low, z_high,
		input ready);
	modport sink (input valid, status_byte, x_low, x_high, y_low, y_high, z_low, z_high,
		output ready);
endinterface

interface mhu_out_if import mhu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     not_ready;
	logic signed [AXIS_W-1:0] x_value;
	logic signed [AXIS_W-1:0] y_value;
	logic signed [AXIS_W-1:0] z_value;
	logic [HEAD_W-1:0]        heading;

	modport source (output valid, not_ready, x_value, y_value, z_value, heading, input ready);
	modport sink (input valid, not_ready, x_value, y_value, z_value, heading, output ready);
endinterface
`default_nettype wire

// ===== design/magnetometer_heading_unit.sv =====
// Top level: poll decode, CORDIC sequencer, heading rounding, held values and result register.
//
//  channel  dir  beat contents
//  poll     in   status_byte, x/y/z low and high bytes
//  result   out  not_ready, x_value, y_value, z_value, heading
//
// A fresh sample with X and Y both nonzero goes through load, the CORDIC steps of the shared
// unit, rounding and emit; the next poll is taken once the block is back in idle, after the
// result register has taken the result. X or Y zero skips the steps. A poll with the ready
// bit clear goes from accept straight to emit. One poll in flight.
// Reset clears the held axes and heading to zero and empties the result register.
// A stalled result holds the block in its emit state; poll is not ready meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module magnetometer_heading_unit import mhu_pkg::*; #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mhu_in_if.sink     poll,
	mhu_out_if.source  result
);

	localparam int ITER_N = (ANGLE_ITERATIONS > TABLE_LEN) ? TABLE_LEN : ANGLE_ITERATIONS;
	localparam int ITER_W = $clog2(ITER_N);
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITER_N - 1);

	mhu_state_t state_q, state_d;
	logic [ITER_W-1:0] cnt_q;

	logic signed [AXIS_W-1:0] x_q, y_q, z_q;
	logic                     nr_q;
	logic signed [AXIS_W-1:0] held_x_q, held_y_q, held_z_q;
	logic [HEAD_W-1:0]        held_heading_q;

	logic                     out_valid_q;
	logic                     out_nr_q;
	logic signed [AXIS_W-1:0] out_x_q, out_y_q, out_z_q;
	logic [HEAD_W-1:0]        out_heading_q;

	mhu_cordic_ctrl_t        cctrl;
	logic signed [ANG_W-1:0] angle;
	logic signed [ANG_W-1:0] rsum;
	logic signed [ROUND_W-1:0] rsteps, rwrap;

	logic poll_acc, out_free, special;

	assign poll_acc = poll.valid && poll.ready;
	assign out_free = !out_valid_q || result.ready;
	assign special  = (x_q == '0) || (y_q == '0);

	mhu_cordic u_cordic (
		.clk   (clk),
		.ctrl  (cctrl),
		.x_in  (x_q),
		.y_in  (y_q),
		.angle (angle)
	);

	// sequencer: next state and commands
	always_comb begin
		state_d    = state_q;
		poll.ready = 1'b0;
		cctrl.load = 1'b0;
		cctrl.step = 1'b0;
		cctrl.idx  = IDX_W'(cnt_q);
		unique case (state_q)
			ST_IDLE: begin
				poll.ready = 1'b1;
				if (poll.valid) begin
					state_d = poll.status_byte[STATUS_READY_BIT] ? ST_LOAD : ST_EMIT;
				end
			end
			ST_LOAD: begin
				cctrl.load = 1'b1;
				state_d    = special ? ST_ROUND : ST_ITER;
			end
			ST_ITER: begin
				cctrl.step = 1'b1;
				if (cnt_q == ITER_LAST) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// round half up to 1/64 degree, then fold zero and negatives into (0, 360]
	always_comb begin
		rsum   = angle + RND_HALF;
		rsteps = rsum[ANG_W-1:RND_SHIFT];
		rwrap  = (rsteps <= 0) ? rsteps + STEPS_FULL : rsteps;
	end

	// sample capture and iteration count
	always_ff @(posedge clk) begin
		if (poll_acc) begin
			x_q  <= signed'({poll.x_high, poll.x_low});
			y_q  <= signed'({poll.y_high, poll.y_low});
			z_q  <= signed'({poll.z_high, poll.z_low});
			nr_q <= !poll.status_byte[STATUS_READY_BIT];
		end
		if (state_q == ST_LOAD) begin
			cnt_q <= '0;
		end else if (state_q == ST_ITER) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// held axes and heading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q       <= '0;
			held_y_q       <= '0;
			held_z_q       <= '0;
			held_heading_q <= '0;
		end else if (state_q == ST_ROUND) begin
			held_x_q       <= x_q;
			held_y_q       <= y_q;
			held_z_q       <= z_q;
			held_heading_q <= rwrap[HEAD_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_nr_q      <= nr_q;
			out_x_q       <= held_x_q;
			out_y_q       <= held_y_q;
			out_z_q       <= held_z_q;
			out_heading_q <= held_heading_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.not_ready = out_nr_q;
	assign result.x_value   = out_x_q;
	assign result.y_value   = out_y_q;
	assign result.z_value   = out_z_q;
	assign result.heading   = out_heading_q;

	// checks
	`MHU_ASSERT_IMP(a_fresh_heading_range, result.valid && !result.not_ready,
		result.heading != '0 && result.heading <= STEPS_FULL[HEAD_W-1:0],
		"fresh heading outside (0, 360] degrees")
	`MHU_ASSERT_NXT(a_stale_poll_emits, poll_acc && !poll.status_byte[STATUS_READY_BIT],
		state_q == ST_EMIT && nr_q, "poll without data ready did not go to emit")
	`MHU_ASSERT_NXT(a_iter_ends, state_q == ST_ITER && cnt_q == ITER_LAST,
		state_q == ST_ROUND, "CORDIC iterations did not end at the last step")
	`MHU_ASSERT_NXT(a_emit_loads, state_q == ST_EMIT && out_free,
		out_valid_q && out_nr_q == $past(nr_q), "result register not loaded on emit")

endmodule
`default_nettype wire

// ===== design/mhu_cordic.sv =====
// Shared CORDIC vectoring step unit: quadrant load, one micro-rotation per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mhu_cordic import mhu_pkg::*; (
	input  wire  logic                     clk,
	input  wire  mhu_cordic_ctrl_t         ctrl,
	input  wire  logic signed [AXIS_W-1:0] x_in,
	input  wire  logic signed [AXIS_W-1:0] y_in,
	output logic signed [ANG_W-1:0]        angle
);

	logic signed [VEC_W-1:0] u_q, v_q;
	logic signed [ANG_W-1:0] z_q;

	logic signed [VEC_W-1:0] u_ld, v_ld, u_ext, v_ext;
	logic signed [ANG_W-1:0] z_ld;
	logic signed [VEC_W-1:0] du, dv;
	logic signed [ANG_W-1:0] dz;

	// load: u = Y, v = X, scaled; fold the left half-plane by +-90 degrees
	always_comb begin
		u_ext = {{(VEC_W-AXIS_W-IN_SHIFT){y_in[AXIS_W-1]}}, y_in, {IN_SHIFT{1'b0}}};
		v_ext = {{(VEC_W-AXIS_W-IN_SHIFT){x_in[AXIS_W-1]}}, x_in, {IN_SHIFT{1'b0}}};
		u_ld  = u_ext;
		v_ld  = v_ext;
		z_ld  = ANG_ZERO;
		if (x_in == '0) begin
			// on the Y axis: exactly 0 or 180 degrees
			z_ld = (y_in < 0) ? ANG_180 : ANG_ZERO;
		end else if (y_in == '0) begin
			z_ld = (x_in > 0) ? ANG_90 : -ANG_90;
		end else if (u_ext < 0) begin
			if (v_ext > 0) begin
				u_ld = v_ext;
				v_ld = -u_ext;
				z_ld = ANG_90;
			end else begin
				u_ld = -v_ext;
				v_ld = u_ext;
				z_ld = -ANG_90;
			end
		end
	end

	// one micro-rotation: floor shifts, add/sub driven by the sign of v
	always_comb begin
		du = u_q >>> ctrl.idx;
		dv = v_q >>> ctrl.idx;
		dz = signed'({{(ANG_W-LUT_W){1'b0}}, atan_lut(ctrl.idx)});
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			u_q <= u_ld;
			v_q <= v_ld;
			z_q <= z_ld;
		end else if (ctrl.step) begin
			if (v_q >= 0) begin
				u_q <= u_q + dv;
				v_q <= v_q - du;
				z_q <= z_q + dz;
			end else begin
				u_q <= u_q - dv;
				v_q <= v_q + du;
				z_q <= z_q - dz;
			end
		end
	end

	assign angle = z_q;

endmodule
`default_nettype wire
